// ===== rtl/wamm_pkg.sv =====
// shared widths, sequencer states and constants for the windowed average tracker
package wamm_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int WINDOW_BITS  = 16;
  localparam int SUM_WIDTH    = SAMPLE_WIDTH + WINDOW_BITS;
  localparam int STEP_WIDTH   = $clog2(SUM_WIDTH);
  localparam int CFG_WIDTH    = 32;

  localparam logic [WINDOW_BITS-1:0]  WINDOW_LENGTH_RESET  = WINDOW_BITS'(1);
  localparam logic [SAMPLE_WIDTH-1:0] INVALID_MARKER_RESET = SAMPLE_WIDTH'(-65536);

  typedef enum logic {
    REG_WINDOW_LENGTH  = 1'b0,
    REG_INVALID_MARKER = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_t;

endpackage

// ===== rtl/wamm_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module wamm_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [wamm_pkg::SUM_WIDTH-1:0]      dividend,
  input  logic [wamm_pkg::WINDOW_BITS-1:0]    divisor,
  output logic                                done,
  output logic [wamm_pkg::SUM_WIDTH-1:0]      quotient
);

  logic                                 busy;
  logic [wamm_pkg::STEP_WIDTH-1:0]      step;
  logic [wamm_pkg::WINDOW_BITS-1:0]     rem;
  logic [wamm_pkg::WINDOW_BITS-1:0]     dvs;
  logic [wamm_pkg::SUM_WIDTH-1:0]       quo;
  logic [wamm_pkg::WINDOW_BITS:0]       shifted;
  logic [wamm_pkg::WINDOW_BITS:0]       diff;
  logic                                 fits;

  // shared subtract and compare
  always_comb begin
    shifted = {rem, quo[wamm_pkg::SUM_WIDTH-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= wamm_pkg::STEP_WIDTH'(wamm_pkg::SUM_WIDTH - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[wamm_pkg::WINDOW_BITS-1:0] : shifted[wamm_pkg::WINDOW_BITS-1:0];
      quo <= {quo[wamm_pkg::SUM_WIDTH-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/windowed_average_min_max_tracker.sv =====
// top level: min/max tracking, window accumulation and average sequencer
//
//   channel   signals                                   direction
//   input     in_valid in_ready sample                  in
//   result    out_valid out_ready window_average ...    out
//   config    cfg_write cfg_index cfg_data              in
//
// an item passes from transfer through the divider, the done handoff and the load
// of the output register; an item whose window holds no valid sample skips the
// divider.
// reset is synchronous and clears all control and tracking state.
// a result waiting on out_ready holds the next item in the sequencer.
module windowed_average_min_max_tracker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [wamm_pkg::SAMPLE_WIDTH-1:0] sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wamm_pkg::SAMPLE_WIDTH-1:0] window_average,
  output logic                                  new_window,
  output logic signed [wamm_pkg::SAMPLE_WIDTH-1:0] minimum,
  output logic signed [wamm_pkg::SAMPLE_WIDTH-1:0] maximum,
  output logic        [wamm_pkg::SAMPLE_WIDTH-1:0] spread,
  output logic signed [wamm_pkg::SAMPLE_WIDTH-1:0] midpoint,
  input  logic                                  cfg_write,
  input  logic                                  cfg_index,
  input  logic        [wamm_pkg::CFG_WIDTH-1:0] cfg_data
);

  localparam int SW = wamm_pkg::SAMPLE_WIDTH;
  localparam int WB = wamm_pkg::WINDOW_BITS;
  localparam int UW = wamm_pkg::SUM_WIDTH;

  wamm_pkg::state_t state, state_next;
  logic div_start;
  logic div_done;

  logic [WB-1:0] window_length;
  logic [SW-1:0] invalid_marker;

  logic                 seen_any;
  logic signed [SW-1:0] low_mark;
  logic signed [SW-1:0] high_mark;
  logic [UW-1:0]        window_sum;
  logic [WB-1:0]        valid_count;
  logic [WB-1:0]        window_position;

  logic p_new;
  logic p_neg;
  logic p_zero;

  logic                 accept;
  logic                 load_out;
  logic                 is_valid;
  logic signed [SW-1:0] low_next;
  logic signed [SW-1:0] high_next;
  logic [UW-1:0]        sum_upd;
  logic [WB-1:0]        count_upd;
  logic [WB-1:0]        len_eff;
  logic [WB-1:0]        pos_inc;
  logic                 close;
  logic [UW-1:0]        mag;
  logic [UW-1:0]        quotient;
  logic [UW-1:0]        avg_full;
  logic [SW:0]          mid_sum;

  // datapath for an accepted sample
  always_comb begin
    is_valid  = sample != invalid_marker;
    low_next  = (!seen_any || sample < low_mark) ? sample : low_mark;
    high_next = (!seen_any || sample > high_mark) ? sample : high_mark;
    sum_upd   = window_sum + (is_valid ? UW'(sample) : '0);
    count_upd = valid_count + WB'(is_valid);
    len_eff   = (window_length == '0) ? WB'(1) : window_length;
    pos_inc   = window_position + 1'b1;
    close     = (pos_inc >= len_eff) || (pos_inc == '0);
    mag       = sum_upd[UW-1] ? (~sum_upd + 1'b1) : sum_upd;
    avg_full  = p_zero ? '0 : (p_neg ? (~quotient + 1'b1) : quotient);
    mid_sum   = {low_mark[SW-1], low_mark} + {high_mark[SW-1], high_mark};
  end

  // sequencer
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    div_start  = 1'b0;
    accept     = 1'b0;
    unique case (state)
      wamm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          accept     = 1'b1;
          div_start  = count_upd != '0;
          state_next = (count_upd != '0) ? wamm_pkg::S_DIV : wamm_pkg::S_HOLD;
        end
      end
      wamm_pkg::S_DIV: begin
        if (div_done) state_next = wamm_pkg::S_HOLD;
      end
      wamm_pkg::S_HOLD: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = wamm_pkg::S_IDLE;
        end
      end
      default: state_next = wamm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= wamm_pkg::S_IDLE;
    else     state <= state_next;
  end

  wamm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (count_upd),
    .done     (div_done),
    .quotient (quotient)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= wamm_pkg::WINDOW_LENGTH_RESET;
      invalid_marker <= wamm_pkg::INVALID_MARKER_RESET;
    end else if (cfg_write) begin
      unique case (wamm_pkg::reg_index_t'(cfg_index))
        wamm_pkg::REG_WINDOW_LENGTH:  window_length  <= cfg_data[WB-1:0];
        wamm_pkg::REG_INVALID_MARKER: invalid_marker <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any        <= 1'b0;
      low_mark        <= '0;
      high_mark       <= '0;
      window_sum      <= '0;
      valid_count     <= '0;
      window_position <= '0;
    end else if (accept) begin
      seen_any        <= 1'b1;
      low_mark        <= low_next;
      high_mark       <= high_next;
      window_sum      <= close ? '0 : sum_upd;
      valid_count     <= close ? '0 : count_upd;
      window_position <= close ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_new  <= window_position == '0;
      p_neg  <= sum_upd[UW-1];
      p_zero <= count_upd == '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      window_average <= avg_full[SW-1:0];
      new_window     <= p_new;
      minimum        <= low_mark;
      maximum        <= high_mark;
      spread         <= high_mark - low_mark;
      midpoint       <= mid_sum[SW:1];
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != wamm_pkg::S_IDLE))
    else $error("sequencer stayed idle after a transfer");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == wamm_pkg::S_DIV))
    else $error("divider finished outside the divide phase");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    seen_any |-> (low_mark <= high_mark))
    else $error("tracked minimum above maximum");

  a_count_le_pos: assert property (@(posedge clk) disable iff (rst)
    valid_count <= window_position)
    else $error("valid count exceeds window position");

endmodule
